>>> sv/sha1_hash_engine_top_macros.svh
// Assertion macros for the SHA-1 engine checker.
// Used by sha1_checker.sv; expects clk_i and rst_ni in the enclosing scope.
`ifndef SHA1_HASH_ENGINE_TOP_MACROS_SVH
`define SHA1_HASH_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SHA1_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha1 engine: property failed");

// Next-cycle implication, disabled while in reset
`define SHA1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha1 engine: property failed");

`endif

>>> sv/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 engine.
// No dependencies; used by the controller, datapath and top level.
package sha1_pkg;

  typedef logic [31:0] word_t;

  // Initial chain value
  localparam word_t H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants
  localparam word_t K_CH   = 32'h5A827999;
  localparam word_t K_PAR1 = 32'h6ED9EBA1;
  localparam word_t K_MAJ  = 32'h8F1BBCDC;
  localparam word_t K_PAR2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;  // bit 448: start of length field
  localparam logic [5:0] LAST_POS  = 6'd63;  // bit 504: last byte of a block
  localparam logic [6:0] ROUNDS    = 7'd80;
  localparam logic [2:0] LAST_IDX  = 3'd4;

  typedef enum logic [1:0] {
    RK_CH   = 2'd0,
    RK_PAR1 = 2'd1,
    RK_MAJ  = 2'd2,
    RK_PAR2 = 2'd3
  } round_kind_e;

  typedef enum logic [1:0] {
    BS_DATA = 2'd0,
    BS_PAD  = 2'd1,
    BS_ZERO = 2'd2,
    BS_LEN  = 2'd3
  } byte_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic        push;
    byte_sel_e   byte_sel;
    logic        count_len;
    logic        load_work;
    logic        round;
    round_kind_e kind;
    logic        finish;
    logic        clear_msg;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_last;
    logic fill_len_pos;
  } dp_stat_t;

  function automatic word_t rotl1(word_t v);
    return {v[30:0], v[31]};
  endfunction

  function automatic word_t rotl5(word_t v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic word_t rotl30(word_t v);
    return {v[1:0], v[31:2]};
  endfunction

  function automatic word_t round_f(round_kind_e kind, word_t b, word_t c, word_t d);
    word_t f;
    case (kind)
      RK_CH:   f = (b & c) | (~b & d);
      RK_MAJ:  f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t round_k(round_kind_e kind);
    word_t k;
    case (kind)
      RK_CH:   k = K_CH;
      RK_PAR1: k = K_PAR1;
      RK_MAJ:  k = K_MAJ;
      default: k = K_PAR2;
    endcase
    return k;
  endfunction

endpackage

>>> sv/sha1_if.sv
// Valid/ready channel interfaces of the SHA-1 engine: byte input, digest output.
// No dependencies.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> sv/sha1_ctrl.sv
// SHA-1 engine controller: input handshake, padding sequence, round count, digest output.
// Depends on sha1_pkg.
module sha1_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_has_byte_i,
  input  logic               in_last_byte_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         word_idx_o,
  output logic               last_word_o,
  input  sha1_pkg::dp_stat_t stat_i,
  output sha1_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    PH_MARK = 3'b001,
    PH_ZERO = 3'b010,
    PH_LEN  = 3'b100
  } phase_e;

  localparam logic [6:0] RndStage1 = 7'd20;
  localparam logic [6:0] RndStage2 = 7'd40;
  localparam logic [6:0] RndStage3 = 7'd60;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        last_q, last_d;
  logic        done_q, done_d;
  logic        in_fire;
  sha1_pkg::round_kind_e kind;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign word_idx_o  = idx_q;
  assign last_word_o = (idx_q == sha1_pkg::LAST_IDX);

  // Round function by round number
  always_comb begin
    if (rnd_q < RndStage1) begin
      kind = sha1_pkg::RK_CH;
    end else if (rnd_q < RndStage2) begin
      kind = sha1_pkg::RK_PAR1;
    end else if (rnd_q < RndStage3) begin
      kind = sha1_pkg::RK_MAJ;
    end else begin
      kind = sha1_pkg::RK_PAR2;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    last_d  = last_q;
    done_d  = done_q;

    cmd_o.push      = 1'b0;
    cmd_o.byte_sel  = sha1_pkg::BS_DATA;
    cmd_o.count_len = 1'b0;
    cmd_o.load_work = 1'b0;
    cmd_o.round     = 1'b0;
    cmd_o.kind      = kind;
    cmd_o.finish    = 1'b0;
    cmd_o.clear_msg = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          last_d  = in_last_byte_i;
          phase_d = PH_MARK;
          if (in_has_byte_i) begin
            cmd_o.push      = 1'b1;
            cmd_o.count_len = 1'b1;
            if (stat_i.fill_last) begin
              cmd_o.load_work = 1'b1;
              rnd_d           = '0;
              state_d         = ST_COMP;
            end else if (in_last_byte_i) begin
              state_d = ST_PAD;
            end
          end else if (in_last_byte_i) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        unique case (phase_q)
          PH_MARK: begin
            cmd_o.push     = 1'b1;
            cmd_o.byte_sel = sha1_pkg::BS_PAD;
            phase_d        = PH_ZERO;
          end
          PH_ZERO: begin
            if (stat_i.fill_len_pos) begin
              phase_d = PH_LEN;
            end else begin
              cmd_o.push     = 1'b1;
              cmd_o.byte_sel = sha1_pkg::BS_ZERO;
            end
          end
          PH_LEN: begin
            cmd_o.push     = 1'b1;
            cmd_o.byte_sel = sha1_pkg::BS_LEN;
            if (stat_i.fill_last) begin
              done_d = 1'b1;
            end
          end
          default: phase_d = PH_MARK;
        endcase
        // block full: compress before padding goes on
        if (cmd_o.push && stat_i.fill_last) begin
          cmd_o.load_work = 1'b1;
          rnd_d           = '0;
          state_d         = ST_COMP;
        end
      end

      ST_COMP: begin
        if (rnd_q == sha1_pkg::ROUNDS) begin
          cmd_o.finish = 1'b1;
          if (done_q) begin
            idx_d   = '0;
            state_d = ST_EMIT;
          end else if (last_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.round = 1'b1;
          rnd_d       = rnd_q + 7'd1;
        end
      end

      ST_EMIT: begin
        if (out_ready_i) begin
          if (idx_q == sha1_pkg::LAST_IDX) begin
            cmd_o.clear_msg = 1'b1;
            last_d          = 1'b0;
            done_d          = 1'b0;
            state_d         = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MARK;
      rnd_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> sv/sha1_dp.sv
// SHA-1 engine datapath: block shift register, message schedule, round unit, chain value.
// Depends on sha1_pkg; driven by sha1_ctrl through dp_cmd_t.
module sha1_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha1_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic [2:0]         word_idx_i,
  output sha1_pkg::dp_stat_t stat_o,
  output sha1_pkg::word_t    digest_word_o
);

  sha1_pkg::word_t chain_q [5];
  logic [5:0]      fill_q;
  logic [63:0]     bit_len_q;
  logic [511:0]    blk_q;
  sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;

  logic [7:0]      push_byte;
  logic [7:0]      len_byte;
  sha1_pkg::word_t w0, w2, w8, w13, w_new, t_sum;

  assign stat_o.fill_last    = (fill_q == sha1_pkg::LAST_POS);
  assign stat_o.fill_len_pos = (fill_q == sha1_pkg::LEN_POS);

  // Length field, most significant byte first, picked by position in the field
  assign len_byte = 8'(bit_len_q >> {~fill_q[2:0], 3'b000});

  always_comb begin
    case (cmd_i.byte_sel)
      sha1_pkg::BS_DATA: push_byte = data_byte_i;
      sha1_pkg::BS_PAD:  push_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::BS_ZERO: push_byte = 8'h00;
      default:           push_byte = len_byte;
    endcase
  end

  // Schedule window: word j of the window sits at blk_q[511-32j -: 32]
  assign w0    = blk_q[511:480];
  assign w2    = blk_q[447:416];
  assign w8    = blk_q[255:224];
  assign w13   = blk_q[95:64];
  assign w_new = sha1_pkg::rotl1(w13 ^ w8 ^ w2 ^ w0);

  assign t_sum = sha1_pkg::rotl5(a_q) + sha1_pkg::round_f(cmd_i.kind, b_q, c_q, d_q)
               + e_q + sha1_pkg::round_k(cmd_i.kind) + w0;

  // Digest word select
  always_comb begin
    case (word_idx_i)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      default: digest_word_o = chain_q[4];
    endcase
  end

  // Block shift register and working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      blk_q <= {blk_q[503:0], push_byte};
    end else if (cmd_i.round) begin
      blk_q <= {blk_q[479:0], w_new};
    end
    if (cmd_i.load_work) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= sha1_pkg::rotl30(b_q);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // Message state: chain value, fill position, bit length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q   <= sha1_pkg::H_INIT;
      fill_q    <= '0;
      bit_len_q <= '0;
    end else if (cmd_i.clear_msg) begin
      chain_q   <= sha1_pkg::H_INIT;
      fill_q    <= '0;
      bit_len_q <= '0;
    end else begin
      if (cmd_i.push) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.count_len) begin
        bit_len_q <= bit_len_q + 64'd8;
      end
      if (cmd_i.finish) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
    end
  end

endmodule

>>> sv/sha1_hash_engine_top.sv
// Channel    | Dir | Payload                                  | Transfer
// in_ch_i    | in  | data_byte[7:0], has_byte, last_byte      | valid & ready
// out_ch_o   | out | digest_word[31:0], word_index[2:0], last | valid & ready
//
// A byte item is stored into the block; the item that completes a 64-byte block is
// stored, run through 80 rounds of the single round unit, then added into the chain.
// A final item then pads one byte a cycle, except while a block is compressed, with
// a pause before the length field, compressing one or two more blocks, and presents
// the five digest words, one per cycle while the sink is ready.
// Input stalls during each compression, and from a final item until the digest
// is fully transferred.
// Asynchronous active-low reset loads the initial chain value and clears the length.
// Top level of the SHA-1 engine; depends on sha1_pkg, sha1_if, sha1_ctrl and sha1_dp.
module sha1_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sha1_in_if.sink     in_ch_i,
  sha1_out_if.source  out_ch_o
);

  sha1_pkg::dp_cmd_t  cmd;
  sha1_pkg::dp_stat_t stat;
  logic [2:0]         word_idx;

  sha1_ctrl u_sha1_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch_i.valid),
    .in_has_byte_i  (in_ch_i.has_byte),
    .in_last_byte_i (in_ch_i.last_byte),
    .in_ready_o     (in_ch_i.ready),
    .out_valid_o    (out_ch_o.valid),
    .out_ready_i    (out_ch_o.ready),
    .word_idx_o     (word_idx),
    .last_word_o    (out_ch_o.last_word),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  sha1_dp u_sha1_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_ch_i.data_byte),
    .word_idx_i    (word_idx),
    .stat_o        (stat),
    .digest_word_o (out_ch_o.digest_word)
  );

  assign out_ch_o.word_index = word_idx;

endmodule

>>> sv/sha1_checker.sv
// Port-level checks of the SHA-1 engine, bound to the top level.
// Depends on sha1_hash_engine_top_macros.svh.
`include "sha1_hash_engine_top_macros.svh"

module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  // No input is taken while the digest is being presented
  `SHA1_ASSERT_NOW(a_no_input_during_digest, out_valid_i, !in_ready_i)

  // last_word marks word four, and the index never passes it
  `SHA1_ASSERT_NOW(a_last_word_index, out_valid_i,
                   (word_index_i <= 3'd4) && (last_word_i == (word_index_i == 3'd4)))

  // Digest words come in order without a gap
  `SHA1_ASSERT_NEXT(a_word_order, out_valid_i && out_ready_i && !last_word_i,
                    out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))

  // A stalled word holds
  `SHA1_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(digest_word_i) && $stable(word_index_i))

endmodule

bind sha1_hash_engine_top sha1_checker u_sha1_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .digest_word_i (out_ch_o.digest_word),
  .word_index_i  (out_ch_o.word_index),
  .last_word_i   (out_ch_o.last_word)
);
